### hdl/lidar_point_decimate_rotate_unit_assert.svh
// assertion macros for the lidar point rotate block
`ifndef LIDAR_POINT_DECIMATE_ROTATE_UNIT_ASSERT_SVH
`define LIDAR_POINT_DECIMATE_ROTATE_UNIT_ASSERT_SVH

// same-cycle implication
`define LPDR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpdr assertion failed");

// next-cycle implication
`define LPDR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpdr assertion failed");

`endif

### hdl/lpdr_pkg.sv
package lpdr_pkg;

  localparam int COORD_BITS_DEF       = 20;
  localparam int MAX_CLOUD_POINTS_DEF = 1048576;

  localparam int QUAT_BITS  = 16;
  localparam int STEP_BITS  = 23;
  localparam int ACC_BITS   = 38;
  localparam int MID_BITS   = 47;
  localparam int FRAC_BITS  = 28;
  localparam int IDX_FRAC   = 16;
  localparam int NUM_STEPS  = 24;
  localparam int STEP_CNT_BITS = $clog2(NUM_STEPS);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = STEP_BITS;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUAT_W = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUAT_X = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUAT_Y = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUAT_Z = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP   = 3'd4;

  localparam logic signed [QUAT_BITS-1:0] QUAT_W_RESET = 16'sd16384;
  localparam logic [STEP_BITS-1:0]        STEP_RESET   = 23'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  // multiplier vector operand
  typedef enum logic [2:0] {
    OP_VX,
    OP_VY,
    OP_VZ,
    OP_TW,
    OP_TX,
    OP_TY,
    OP_TZ
  } opnd_t;

  // multiplier quaternion operand
  typedef enum logic [1:0] {
    Q_W,
    Q_X,
    Q_Y,
    Q_Z
  } qsel_t;

  typedef struct packed {
    opnd_t      a_sel;
    qsel_t      q_sel;
    logic       neg;
    logic       first;
    logic       last;
    logic       ph2;
    logic [1:0] dst;
    logic       fin;
  } sched_t;

  function automatic sched_t mk(input opnd_t a, input qsel_t q, input logic neg,
                                input logic first, input logic last,
                                input logic ph2, input logic [1:0] dst,
                                input logic fin);
    sched_t r;
    r.a_sel = a;
    r.q_sel = q;
    r.neg   = neg;
    r.first = first;
    r.last  = last;
    r.ph2   = ph2;
    r.dst   = dst;
    r.fin   = fin;
    return r;
  endfunction

  // first pass forms t = q*v, second pass r = t*conj(q), one product a step
  function automatic sched_t sched(input logic [STEP_CNT_BITS-1:0] s);
    sched_t r;
    case (s)
      5'd0:  r = mk(OP_VX, Q_X, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
      5'd1:  r = mk(OP_VY, Q_Y, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
      5'd2:  r = mk(OP_VZ, Q_Z, 1'b1, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0);
      5'd3:  r = mk(OP_VX, Q_W, 1'b0, 1'b1, 1'b0, 1'b0, 2'd1, 1'b0);
      5'd4:  r = mk(OP_VZ, Q_Y, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1, 1'b0);
      5'd5:  r = mk(OP_VY, Q_Z, 1'b1, 1'b0, 1'b1, 1'b0, 2'd1, 1'b0);
      5'd6:  r = mk(OP_VY, Q_W, 1'b0, 1'b1, 1'b0, 1'b0, 2'd2, 1'b0);
      5'd7:  r = mk(OP_VZ, Q_X, 1'b1, 1'b0, 1'b0, 1'b0, 2'd2, 1'b0);
      5'd8:  r = mk(OP_VX, Q_Z, 1'b0, 1'b0, 1'b1, 1'b0, 2'd2, 1'b0);
      5'd9:  r = mk(OP_VZ, Q_W, 1'b0, 1'b1, 1'b0, 1'b0, 2'd3, 1'b0);
      5'd10: r = mk(OP_VY, Q_X, 1'b0, 1'b0, 1'b0, 1'b0, 2'd3, 1'b0);
      5'd11: r = mk(OP_VX, Q_Y, 1'b1, 1'b0, 1'b1, 1'b0, 2'd3, 1'b0);
      5'd12: r = mk(OP_TW, Q_X, 1'b1, 1'b1, 1'b0, 1'b1, 2'd0, 1'b0);
      5'd13: r = mk(OP_TX, Q_W, 1'b0, 1'b0, 1'b0, 1'b1, 2'd0, 1'b0);
      5'd14: r = mk(OP_TY, Q_Z, 1'b1, 1'b0, 1'b0, 1'b1, 2'd0, 1'b0);
      5'd15: r = mk(OP_TZ, Q_Y, 1'b0, 1'b0, 1'b1, 1'b1, 2'd0, 1'b0);
      5'd16: r = mk(OP_TW, Q_Y, 1'b1, 1'b1, 1'b0, 1'b1, 2'd1, 1'b0);
      5'd17: r = mk(OP_TX, Q_Z, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1, 1'b0);
      5'd18: r = mk(OP_TY, Q_W, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1, 1'b0);
      5'd19: r = mk(OP_TZ, Q_X, 1'b1, 1'b0, 1'b1, 1'b1, 2'd1, 1'b0);
      5'd20: r = mk(OP_TW, Q_Z, 1'b1, 1'b1, 1'b0, 1'b1, 2'd2, 1'b0);
      5'd21: r = mk(OP_TX, Q_Y, 1'b1, 1'b0, 1'b0, 1'b1, 2'd2, 1'b0);
      5'd22: r = mk(OP_TY, Q_X, 1'b0, 1'b0, 1'b0, 1'b1, 2'd2, 1'b0);
      5'd23: r = mk(OP_TZ, Q_W, 1'b0, 1'b0, 1'b1, 1'b1, 2'd2, 1'b1);
      default: r = mk(OP_VX, Q_W, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0);
    endcase
    return r;
  endfunction

endpackage

### hdl/lidar_point_decimate_rotate_unit.sv
// kept point: the result word is formed by 24 passes through one shared 47x16 multiply-accumulate
// unit plus load and unload; no new point is taken until the result word is loaded.
// decimated or dropped point: accepted with no stall and no result word; the next point may follow straight away.
// a waiting result word sits in the output register while the next point is taken.
// rst is synchronous, active high: config returns to identity quaternion and unit step,
// point index and keep accumulator clear, no result word is pending.
`include "lidar_point_decimate_rotate_unit_assert.svh"

module lidar_point_decimate_rotate_unit #(
  parameter int COORD_BITS       = lpdr_pkg::COORD_BITS_DEF,
  parameter int MAX_CLOUD_POINTS = lpdr_pkg::MAX_CLOUD_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,

  input  logic                                   cfg_write,
  input  logic [lpdr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [lpdr_pkg::CFG_DATA_BITS-1:0]     cfg_data,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cloud_start,
  input  logic signed [COORD_BITS-1:0]           point_x,
  input  logic signed [COORD_BITS-1:0]           point_y,
  input  logic signed [COORD_BITS-1:0]           point_z,
  input  logic [7:0]                             reflectivity,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [COORD_BITS:0]             local_x,
  output logic signed [COORD_BITS:0]             local_y,
  output logic signed [COORD_BITS:0]             local_z,
  output logic signed [COORD_BITS-1:0]           raw_x,
  output logic signed [COORD_BITS-1:0]           raw_y,
  output logic signed [COORD_BITS-1:0]           raw_z,
  output logic [7:0]                             reflect_out
);

  localparam int OW  = COORD_BITS + 1;
  localparam int QW  = lpdr_pkg::QUAT_BITS;
  localparam int MW  = lpdr_pkg::MID_BITS;
  localparam int PW  = MW + QW;
  localparam int AW  = PW + 3;
  localparam int SB  = lpdr_pkg::STEP_BITS;
  localparam int ACW = lpdr_pkg::ACC_BITS;
  localparam int IW  = $clog2(MAX_CLOUD_POINTS);
  localparam int TW  = IW + lpdr_pkg::IDX_FRAC;
  localparam int CW  = ((ACW > TW) ? ACW : TW) + 1;
  localparam int SCW = lpdr_pkg::STEP_CNT_BITS;

  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_CLOUD_POINTS - 1);
  localparam logic signed [AW-1:0] HALF   = AW'(1) <<< (lpdr_pkg::FRAC_BITS - 1);
  localparam logic signed [AW-1:0] MID_HI = (AW'(1) <<< (MW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] MID_LO = -MID_HI;
  localparam logic signed [AW-1:0] OUT_HI = (AW'(1) <<< COORD_BITS) - AW'(1);
  localparam logic signed [AW-1:0] OUT_LO = -OUT_HI - AW'(1);

  // configuration
  logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
  logic [SB-1:0]        decimation_step;

  // decimation state
  logic [IW-1:0]  point_index;
  logic [ACW-1:0] keep_accumulator;

  // sequencer and datapath
  lpdr_pkg::state_t state, state_next;
  logic                 issuing;
  logic [SCW-1:0]       step;
  logic                 prod_valid;
  lpdr_pkg::sched_t     pipe;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic signed [OW-1:0] vx, vy, vz;
  logic signed [MW-1:0] tq [4];
  logic signed [OW-1:0] rx, ry, rz;
  logic signed [COORD_BITS-1:0] cap_x, cap_y, cap_z;
  logic [7:0]           cap_refl;

  logic in_fire;
  logic out_take;
  logic load_out;
  logic start_calc;
  logic keep;
  logic drop;
  logic [IW-1:0]  idx_cur;
  logic [IW-1:0]  idx_next;
  logic [ACW-1:0] acc_base;
  logic [ACW:0]   acc_add;
  logic [ACW-1:0] acc_kept;

  lpdr_pkg::sched_t     cur_sched;
  logic signed [MW-1:0] a_mux;
  logic signed [QW-1:0] q_mux;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] sum_base;
  logic signed [AW-1:0] acc_sum;
  logic signed [AW-1:0] shifted;
  logic signed [MW-1:0] t_clamped;
  logic signed [OW-1:0] r_sat;

  assign in_stall = (state != lpdr_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign load_out = (state == lpdr_pkg::ST_DONE) && (!out_valid || !out_stall);

  // keep decision on the accepted point
  always_comb begin
    idx_cur  = cloud_start ? '0 : point_index;
    idx_next = (idx_cur < IDX_LAST) ? idx_cur + IW'(1) : idx_cur;
    acc_base = cloud_start ? '0 : keep_accumulator;
    keep     = CW'(acc_base) <= (CW'(idx_cur) << lpdr_pkg::IDX_FRAC);
    acc_add  = {1'b0, acc_base} + (ACW + 1)'(decimation_step);
    acc_kept = acc_add[ACW] ? {ACW{1'b1}} : acc_add[ACW-1:0];
    drop     = (point_x <= 0) && (point_y == 0) && (point_z == 0);
    start_calc = in_fire && keep && !drop;
  end

  // operand selection for the shared multiplier
  always_comb begin
    cur_sched = lpdr_pkg::sched(step);
    case (cur_sched.a_sel)
      lpdr_pkg::OP_VX: a_mux = MW'(vx);
      lpdr_pkg::OP_VY: a_mux = MW'(vy);
      lpdr_pkg::OP_VZ: a_mux = MW'(vz);
      lpdr_pkg::OP_TW: a_mux = tq[0];
      lpdr_pkg::OP_TX: a_mux = tq[1];
      lpdr_pkg::OP_TY: a_mux = tq[2];
      lpdr_pkg::OP_TZ: a_mux = tq[3];
      default:         a_mux = '0;
    endcase
    case (cur_sched.q_sel)
      lpdr_pkg::Q_W: q_mux = quat_w;
      lpdr_pkg::Q_X: q_mux = quat_x;
      lpdr_pkg::Q_Y: q_mux = quat_y;
      default:       q_mux = quat_z;
    endcase
  end

  // accumulate, clamp the middle product, round and saturate the result
  always_comb begin
    addend = pipe.neg ? -AW'(prod) : AW'(prod);
    // second pass starts at one half so the shift rounds to nearest, ties up
    if (pipe.first) begin
      sum_base = pipe.ph2 ? HALF : '0;
    end else begin
      sum_base = acc;
    end
    acc_sum = sum_base + addend;
    if (acc_sum > MID_HI) begin
      t_clamped = MW'(MID_HI);
    end else if (acc_sum < MID_LO) begin
      t_clamped = MW'(MID_LO);
    end else begin
      t_clamped = MW'(acc_sum);
    end
    shifted = acc_sum >>> lpdr_pkg::FRAC_BITS;
    if (shifted > OUT_HI) begin
      r_sat = OW'(OUT_HI);
    end else if (shifted < OUT_LO) begin
      r_sat = OW'(OUT_LO);
    end else begin
      r_sat = OW'(shifted);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lpdr_pkg::ST_IDLE: begin
        if (start_calc) state_next = lpdr_pkg::ST_CALC;
      end
      lpdr_pkg::ST_CALC: begin
        if (prod_valid && pipe.fin) state_next = lpdr_pkg::ST_DONE;
      end
      lpdr_pkg::ST_DONE: begin
        if (load_out) state_next = lpdr_pkg::ST_IDLE;
      end
      default: state_next = lpdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpdr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w           <= lpdr_pkg::QUAT_W_RESET;
      quat_x           <= '0;
      quat_y           <= '0;
      quat_z           <= '0;
      decimation_step  <= lpdr_pkg::STEP_RESET;
      point_index      <= '0;
      keep_accumulator <= '0;
      issuing          <= 1'b0;
      step             <= '0;
      prod_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          lpdr_pkg::CFG_QUAT_W: quat_w <= cfg_data[QW-1:0];
          lpdr_pkg::CFG_QUAT_X: quat_x <= cfg_data[QW-1:0];
          lpdr_pkg::CFG_QUAT_Y: quat_y <= cfg_data[QW-1:0];
          lpdr_pkg::CFG_QUAT_Z: quat_z <= cfg_data[QW-1:0];
          lpdr_pkg::CFG_STEP:   decimation_step <= cfg_data[SB-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        point_index      <= idx_next;
        keep_accumulator <= keep ? acc_kept : acc_base;
      end
      if (start_calc) begin
        issuing <= 1'b1;
        step    <= '0;
      end else if (issuing) begin
        if (step == SCW'(lpdr_pkg::NUM_STEPS - 1)) begin
          issuing <= 1'b0;
        end else begin
          step <= step + SCW'(1);
        end
      end
      prod_valid <= issuing;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start_calc) begin
      vx       <= OW'(point_z);
      vy       <= -OW'(point_y);
      vz       <= OW'(point_x);
      cap_x    <= point_x;
      cap_y    <= point_y;
      cap_z    <= point_z;
      cap_refl <= reflectivity;
    end
    if (issuing) begin
      prod <= a_mux * q_mux;
      pipe <= cur_sched;
    end
    if (prod_valid) begin
      acc <= acc_sum;
      if (pipe.last) begin
        if (!pipe.ph2) begin
          tq[pipe.dst] <= t_clamped;
        end else begin
          case (pipe.dst)
            2'd0:    rx <= r_sat;
            2'd1:    ry <= r_sat;
            default: rz <= r_sat;
          endcase
        end
      end
    end
    if (load_out) begin
      local_x     <= rx;
      local_y     <= ry;
      local_z     <= rz;
      raw_x       <= cap_x;
      raw_y       <= cap_y;
      raw_z       <= cap_z;
      reflect_out <= cap_refl;
    end
  end

  `LPDR_ASSERT_NEXT(a_start_calc, clk, rst, start_calc,
                    (state == lpdr_pkg::ST_CALC) && issuing && (step == '0))
  `LPDR_ASSERT_NOW(a_prod_in_calc, clk, rst, prod_valid || issuing,
                   state == lpdr_pkg::ST_CALC)
  `LPDR_ASSERT_NEXT(a_load_out, clk, rst, load_out,
                    out_valid && (state == lpdr_pkg::ST_IDLE))
  `LPDR_ASSERT_NEXT(a_acc_grows, clk, rst, in_fire && !cloud_start,
                    keep_accumulator >= $past(keep_accumulator))
  `LPDR_ASSERT_NOW(a_index_range, clk, rst, 1'b1, point_index <= IDX_LAST)

endmodule
